// File: hdl/bcmc_pkg.sv
// ----------------------------------------------------------------------------
// Battery contactor mode control package
// Mode codes, register indexes and reset values shared by the block and its
// checker.
// ----------------------------------------------------------------------------
package bcmc_pkg;

   localparam int unsigned MV_W     = 16;
   localparam int unsigned TEMP_W   = 12;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;

   // operating modes
   localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PRECHARGE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DISCHARGE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CHARGE    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FAULT     = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OVER_VOLTAGE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UNDER_VOLTAGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OVER_TEMP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNDER_TEMP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PRECHARGE_MS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CHARGE_CUTOFF = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CHARGE_RESTART = 3'd6;

   // register reset values
   localparam logic [MV_W-1:0]          RST_OVER_VOLTAGE   = 16'd4200;
   localparam logic [MV_W-1:0]          RST_UNDER_VOLTAGE  = 16'd3000;
   localparam logic signed [TEMP_W-1:0] RST_OVER_TEMP      = 12'sd600;
   localparam logic signed [TEMP_W-1:0] RST_UNDER_TEMP     = 12'sd0;
   localparam logic [MV_W-1:0]          RST_PRECHARGE_MS   = 16'd500;
   localparam logic [MV_W-1:0]          RST_CHARGE_CUTOFF  = 16'd4150;
   localparam logic [MV_W-1:0]          RST_CHARGE_RESTART = 16'd4050;

endpackage

// File: hdl/battery_contactor_mode_control_top.sv
// ----------------------------------------------------------------------------
// Battery contactor mode control
// Five-mode pack supervisor: safety override, latched drive pins, precharge
// timing and charge hysteresis, one sample per transaction.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  req_     | in        | req_valid / req_ready  | cell mV min/max, temperature,
//           |           |                        | charger, load request, now_ms
//  rsp_     | out       | rsp_valid / rsp_ready  | mode and three drive levels
//  csr_     | in        | csr_wr_en              | csr_index, csr_wdata
//
// A transaction is registered on acceptance, then evaluated against the mode
// state and written to the result register; one transaction per cycle is
// sustained while results are drained. The input register advances whenever the
// result register is empty or being drained, so a stalled result stops the
// input side only once both registers are full. Reset is synchronous; it
// empties both registers and restores modes, pins and thresholds.
// ----------------------------------------------------------------------------
module battery_contactor_mode_control_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [bcmc_pkg::MV_W-1:0]              req_min_cell_mv,
   input  logic [bcmc_pkg::MV_W-1:0]              req_max_cell_mv,
   input  logic signed [bcmc_pkg::TEMP_W-1:0]     req_temperature,
   input  logic                                   req_charger_present,
   input  logic                                   req_load_request,
   input  logic [bcmc_pkg::TIME_W-1:0]            req_now_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [bcmc_pkg::MODE_W-1:0]            rsp_mode,
   output logic                                   rsp_precharge_drive,
   output logic                                   rsp_load_enable,
   output logic                                   rsp_charge_enable,
   input  logic                                   csr_wr_en,
   input  logic [bcmc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bcmc_pkg::CSR_DAT_W-1:0]         csr_wdata
);
   import bcmc_pkg::*;

   typedef enum logic [MODE_W-1:0] {
      ST_IDLE      = MODE_IDLE,
      ST_PRECHARGE = MODE_PRECHARGE,
      ST_DISCHARGE = MODE_DISCHARGE,
      ST_CHARGE    = MODE_CHARGE,
      ST_FAULT     = MODE_FAULT
   } mode_state_type;

   // thresholds
   logic [MV_W-1:0]          over_voltage_ff;
   logic [MV_W-1:0]          under_voltage_ff;
   logic signed [TEMP_W-1:0] over_temp_ff;
   logic signed [TEMP_W-1:0] under_temp_ff;
   logic [MV_W-1:0]          precharge_ms_ff;
   logic [MV_W-1:0]          charge_cutoff_ff;
   logic [MV_W-1:0]          charge_restart_ff;

   // input register
   logic                     in_valid_ff;
   logic [MV_W-1:0]          min_mv_ff;
   logic [MV_W-1:0]          max_mv_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic                     charger_ff;
   logic                     load_ff;
   logic [TIME_W-1:0]        now_ff;

   // mode state
   mode_state_type           mode_ff, mode_in;
   logic [TIME_W-1:0]        start_ff, start_in;
   logic                     pre_pin_ff, pre_pin_in;
   logic                     load_pin_ff, load_pin_in;
   logic                     chg_pin_ff, chg_pin_in;

   // result register
   logic                     out_valid_ff;
   logic [MODE_W-1:0]        out_mode_ff;
   logic                     out_pre_ff;
   logic                     out_load_ff;
   logic                     out_chg_ff;

   logic                     advance;
   logic                     ov, uv, ot, ut;
   mode_state_type           mode_eff;
   logic [TIME_W-1:0]        elapsed;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid           = out_valid_ff;
   assign rsp_mode            = out_mode_ff;
   assign rsp_precharge_drive = out_pre_ff;
   assign rsp_load_enable     = out_load_ff;
   assign rsp_charge_enable   = out_chg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         over_voltage_ff   <= RST_OVER_VOLTAGE;
         under_voltage_ff  <= RST_UNDER_VOLTAGE;
         over_temp_ff      <= RST_OVER_TEMP;
         under_temp_ff     <= RST_UNDER_TEMP;
         precharge_ms_ff   <= RST_PRECHARGE_MS;
         charge_cutoff_ff  <= RST_CHARGE_CUTOFF;
         charge_restart_ff <= RST_CHARGE_RESTART;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_OVER_VOLTAGE:   over_voltage_ff   <= csr_wdata;
            REG_UNDER_VOLTAGE:  under_voltage_ff  <= csr_wdata;
            REG_OVER_TEMP:      over_temp_ff      <= csr_wdata[TEMP_W-1:0];
            REG_UNDER_TEMP:     under_temp_ff     <= csr_wdata[TEMP_W-1:0];
            REG_PRECHARGE_MS:   precharge_ms_ff   <= csr_wdata;
            REG_CHARGE_CUTOFF:  charge_cutoff_ff  <= csr_wdata;
            REG_CHARGE_RESTART: charge_restart_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register: capture on acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         min_mv_ff  <= req_min_cell_mv;
         max_mv_ff  <= req_max_cell_mv;
         temp_ff    <= req_temperature;
         charger_ff <= req_charger_present;
         load_ff    <= req_load_request;
         now_ff     <= req_now_ms;
      end
   end

   always_comb begin
      ov       = max_mv_ff >= over_voltage_ff;
      uv       = min_mv_ff <= under_voltage_ff;
      ot       = temp_ff >= over_temp_ff;
      ut       = temp_ff <= under_temp_ff;
      elapsed  = now_ff - start_ff;
      mode_eff = mode_ff;
      if (ot || (mode_ff != ST_CHARGE && ut)) begin
         mode_eff = ST_FAULT;
      end

      mode_in     = mode_eff;
      start_in    = start_ff;
      pre_pin_in  = pre_pin_ff;
      load_pin_in = load_pin_ff;
      chg_pin_in  = chg_pin_ff;

      unique case (mode_eff)
         ST_PRECHARGE: begin
            pre_pin_in = 1'b1;
            if (elapsed >= {{(TIME_W-MV_W){1'b0}}, precharge_ms_ff}) begin
               mode_in = ST_DISCHARGE;
            end
            if (!load_ff || uv) begin
               mode_in = ST_IDLE;
            end
         end
         ST_DISCHARGE: begin
            load_pin_in = 1'b1;
            pre_pin_in  = 1'b1;
            if (!load_ff) begin
               mode_in = ST_IDLE;
            end
            if (uv) begin
               mode_in = ST_FAULT;
            end
         end
         ST_CHARGE: begin
            load_pin_in = 1'b0;
            // cutoff/restart hysteresis on the highest cell
            if (max_mv_ff >= charge_cutoff_ff) begin
               chg_pin_in = 1'b0;
            end else if (max_mv_ff < charge_restart_ff) begin
               chg_pin_in = 1'b1;
            end
            if (!charger_ff) begin
               mode_in = ST_IDLE;
            end
            if (ot || ov) begin
               chg_pin_in = 1'b0;
            end
         end
         ST_FAULT: begin
            pre_pin_in  = 1'b0;
            load_pin_in = 1'b0;
            chg_pin_in  = 1'b0;
            if (!ot && !uv && !ov) begin
               mode_in = ST_IDLE;
            end
         end
         default: begin
            // idle, and any code that cannot arise
            pre_pin_in  = 1'b0;
            load_pin_in = 1'b0;
            chg_pin_in  = 1'b0;
            mode_in     = ST_IDLE;
            if (charger_ff && !ov && !ot) begin
               mode_in = ST_CHARGE;
            end else if (load_ff && !uv && !ot) begin
               mode_in  = ST_PRECHARGE;
               start_in = now_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ST_IDLE;
         start_ff     <= '0;
         pre_pin_ff   <= 1'b0;
         load_pin_ff  <= 1'b0;
         chg_pin_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            mode_ff     <= mode_in;
            start_ff    <= start_in;
            pre_pin_ff  <= pre_pin_in;
            load_pin_ff <= load_pin_in;
            chg_pin_ff  <= chg_pin_in;
         end
         // hold the result until drained
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_mode_ff <= mode_in;
         out_pre_ff  <= pre_pin_in;
         out_load_ff <= load_pin_in;
         out_chg_ff  <= chg_pin_in;
      end
   end

endmodule

// File: hdl/bcmc_checker.sv
// ----------------------------------------------------------------------------
// Battery contactor mode control checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bcmc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [bcmc_pkg::MODE_W-1:0]            rsp_mode,
   input logic                                   rsp_precharge_drive,
   input logic                                   rsp_load_enable,
   input logic                                   rsp_charge_enable
);
   import bcmc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode)
         && $stable(rsp_precharge_drive) && $stable(rsp_load_enable)
         && $stable(rsp_charge_enable))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode == MODE_IDLE || rsp_mode == MODE_PRECHARGE
         || rsp_mode == MODE_DISCHARGE || rsp_mode == MODE_CHARGE
         || rsp_mode == MODE_FAULT)
      else $error("mode code out of range");

   // precharging never drives the load or charger
   a_precharge_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == MODE_PRECHARGE |-> !rsp_load_enable && !rsp_charge_enable)
      else $error("load or charge driven during precharge");

   // charging keeps the load contactor open; discharging keeps precharge drive on
   a_mode_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode != MODE_CHARGE || !rsp_load_enable)
         && (rsp_mode != MODE_DISCHARGE || (rsp_precharge_drive && !rsp_charge_enable)))
      else $error("drive pins inconsistent with mode");

endmodule

bind battery_contactor_mode_control_top bcmc_checker u_bcmc_checker (.*);

// File: tb/battery_contactor_mode_control_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery contactor mode control testbench
// Opens with a table of hand-picked samples, a few with hand-typed results,
// then runs random sample streams under six threshold settings and three
// handshake idle profiles. Results without a hand-typed value are checked
// against a behavioral model of the supervisor kept inside this bench.
// ----------------------------------------------------------------------------
module battery_contactor_mode_control_top_test;
   import bcmc_pkg::*;

   localparam int STALL_LIMIT     = 1000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int NUM_PHASES      = 6;
   // unmapped register index, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   typedef struct {
      logic [MV_W-1:0]          min_mv;
      logic [MV_W-1:0]          max_mv;
      logic signed [TEMP_W-1:0] temp;
      logic                     charger;
      logic                     load;
      logic [TIME_W-1:0]        now;
   } sample_type;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic              pre;
      logic              load;
      logic              chg;
   } status_type;

   typedef struct {
      logic [MV_W-1:0]          ov;
      logic [MV_W-1:0]          uv;
      logic signed [TEMP_W-1:0] ot;
      logic signed [TEMP_W-1:0] ut;
      logic [MV_W-1:0]          pm;
      logic [MV_W-1:0]          cut;
      logic [MV_W-1:0]          rst;
   } limits_type;

   typedef struct {
      logic [MV_W-1:0]          min_mv;
      logic [MV_W-1:0]          max_mv;
      logic signed [TEMP_W-1:0] temp;
      logic                     charger;
      logic                     load;
      logic [TIME_W-1:0]        now;
      logic                     pinned;
      logic [MODE_W-1:0]        mode;
      logic                     pre;
      logic                     load_en;
      logic                     chg;
   } plan_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [MV_W-1:0]             req_min_cell_mv;
   logic [MV_W-1:0]             req_max_cell_mv;
   logic signed [TEMP_W-1:0]    req_temperature;
   logic                        req_charger_present;
   logic                        req_load_request;
   logic [TIME_W-1:0]           req_now_ms;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [MODE_W-1:0]           rsp_mode;
   logic                        rsp_precharge_drive;
   logic                        rsp_load_enable;
   logic                        rsp_charge_enable;
   logic                        csr_wr_en;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DAT_W-1:0]        csr_wdata;

   // hand-typed expectation travels with the transaction
   logic                        req_pinned;
   status_type                  req_pin_val;

   // supervisor model state and its copy of the thresholds
   logic [MODE_W-1:0]           sv_mode;
   logic [TIME_W-1:0]           sv_pc_start;
   logic                        sv_pre;
   logic                        sv_load;
   logic                        sv_chg;
   limits_type                  lim;

   status_type                  pending_status[$];
   int                          err_count;
   int                          n_sent;
   int                          n_results;
   int                          n_settings;
   int                          mode_seen[5];
   int                          send_gap_pct;
   int                          recv_stall_pct;

   // random stream state
   logic                        drv_charger;
   logic                        drv_load;
   logic [TIME_W-1:0]           drv_now;

   plan_row_type opening_plan [25] = '{
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b0, 32'd0,     1'b1, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b1, 1'b1, 32'd10,    1'b1, MODE_CHARGE, 1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b1, 1'b0, 32'd20,    1'b1, MODE_CHARGE, 1'b0, 1'b0, 1'b1},
      '{16'd3500,  16'd4100,  250,   1'b1, 1'b0, 32'd30,    1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd4150,  250,   1'b1, 1'b0, 32'd40,    1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd4100,  250,   1'b1, 1'b0, 32'd50,    1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  -1000, 1'b1, 1'b0, 32'd60,    1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  2000,  1'b1, 1'b0, 32'd70,    1'b1, MODE_FAULT,  1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  -1000, 1'b0, 1'b0, 32'd80,    1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  -1000, 1'b0, 1'b0, 32'd90,    1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3000,  16'd3600,  250,   1'b0, 1'b0, 32'd100,   1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd4200,  250,   1'b0, 1'b0, 32'd110,   1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b0, 32'd120,   1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3000,  16'd3600,  250,   1'b0, 1'b1, 32'd130,   1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b1, 32'hFFFF_FF00, 1'b0, MODE_IDLE, 1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b1, 32'hFFFF_FF64, 1'b0, MODE_IDLE, 1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b1, 32'h0000_00F3, 1'b0, MODE_IDLE, 1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b1, 32'h0000_00F4, 1'b0, MODE_IDLE, 1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b1, 32'd300,   1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3000,  16'd3600,  250,   1'b0, 1'b0, 32'd310,   1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b0, 32'd320,   1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b1, 32'd1000,  1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd3500,  16'd3600,  250,   1'b0, 1'b0, 32'd2000,  1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0},
      '{16'd0,     16'd65535, -1000, 1'b0, 1'b0, 32'd2010,  1'b1, MODE_FAULT,  1'b0, 1'b0, 1'b0},
      '{16'd65535, 16'd0,     250,   1'b0, 1'b0, 32'd2020,  1'b0, MODE_IDLE,   1'b0, 1'b0, 1'b0}
   };

   battery_contactor_mode_control_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_min_cell_mv     (req_min_cell_mv),
      .req_max_cell_mv     (req_max_cell_mv),
      .req_temperature     (req_temperature),
      .req_charger_present (req_charger_present),
      .req_load_request    (req_load_request),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mode            (rsp_mode),
      .rsp_precharge_drive (rsp_precharge_drive),
      .rsp_load_enable     (rsp_load_enable),
      .rsp_charge_enable   (rsp_charge_enable),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety override first, then pins for the mode in effect, then transition.
   function automatic status_type step_supervisor(input sample_type s);
      logic          ov;
      logic          uv;
      logic          ot;
      logic [31:0]   elapsed;
      status_type    r;
      ov = s.max_mv >= lim.ov;
      uv = s.min_mv <= lim.uv;
      ot = s.temp >= lim.ot;
      if (ot || (sv_mode != MODE_CHARGE && s.temp <= lim.ut)) sv_mode = MODE_FAULT;
      case (sv_mode)
         MODE_PRECHARGE: begin
            sv_pre = 1'b1;
            elapsed = s.now - sv_pc_start;
            if (elapsed >= {16'd0, lim.pm}) sv_mode = MODE_DISCHARGE;
            if (!s.load || uv) sv_mode = MODE_IDLE;
         end
         MODE_DISCHARGE: begin
            sv_load = 1'b1;
            sv_pre = 1'b1;
            if (!s.load) sv_mode = MODE_IDLE;
            if (uv) sv_mode = MODE_FAULT;
         end
         MODE_CHARGE: begin
            sv_load = 1'b0;
            if (s.max_mv >= lim.cut) sv_chg = 1'b0;
            else if (s.max_mv < lim.rst) sv_chg = 1'b1;
            if (!s.charger) sv_mode = MODE_IDLE;
            if (ot || ov) sv_chg = 1'b0;
         end
         MODE_FAULT: begin
            sv_pre = 1'b0;
            sv_load = 1'b0;
            sv_chg = 1'b0;
            if (!ot && !uv && !ov) sv_mode = MODE_IDLE;
         end
         default: begin
            sv_pre = 1'b0;
            sv_load = 1'b0;
            sv_chg = 1'b0;
            sv_mode = MODE_IDLE;
            if (s.charger && !ov && !ot) begin
               sv_mode = MODE_CHARGE;
            end else if (s.load && !uv && !ot) begin
               sv_mode = MODE_PRECHARGE;
               sv_pc_start = s.now;
            end
         end
      endcase
      r.mode = sv_mode;
      r.pre = sv_pre;
      r.load = sv_load;
      r.chg = sv_chg;
      return r;
   endfunction

   function automatic void check_field(input string what, input logic [2:0] want,
                                       input logic [2:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      sample_type seen;
      status_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.min_mv = req_min_cell_mv;
            seen.max_mv = req_max_cell_mv;
            seen.temp = req_temperature;
            seen.charger = req_charger_present;
            seen.load = req_load_request;
            seen.now = req_now_ms;
            want = step_supervisor(seen);
            pending_status.push_back(req_pinned ? req_pin_val : want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_status.size() == 0) begin
               $display("%0t: result with nothing expected, actual mode %0d", $time,
                        rsp_mode);
               err_count++;
            end else begin
               want = pending_status.pop_front();
               check_field("mode", want.mode, rsp_mode);
               check_field("precharge_drive", {2'b0, want.pre}, {2'b0, rsp_precharge_drive});
               check_field("load_enable", {2'b0, want.load}, {2'b0, rsp_load_enable});
               check_field("charge_enable", {2'b0, want.chg}, {2'b0, rsp_charge_enable});
               mode_seen[want.mode]++;
            end
            n_results++;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("battery_contactor_mode_control_top_test: FAIL");
      $finish;
   end

   // Call just after the clock rises; the task returns as the sample is accepted.
   task automatic push_sample(input sample_type s, input logic pinned,
                              input status_type pin_val);
      while (int'($urandom_range(0, 99)) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_min_cell_mv <= s.min_mv;
      req_max_cell_mv <= s.max_mv;
      req_temperature <= s.temp;
      req_charger_present <= s.charger;
      req_load_request <= s.load;
      req_now_ms <= s.now;
      req_pinned <= pinned;
      req_pin_val <= pin_val;
      do @(posedge clock); while (!req_ready);
      n_sent++;
   endtask

   // Hold off the sender until every result is back and the pipe is empty.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (n_results < n_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_OVER_VOLTAGE:   lim.ov = data;
         REG_UNDER_VOLTAGE:  lim.uv = data;
         REG_OVER_TEMP:      lim.ot = data[TEMP_W-1:0];
         REG_UNDER_TEMP:     lim.ut = data[TEMP_W-1:0];
         REG_PRECHARGE_MS:   lim.pm = data;
         REG_CHARGE_CUTOFF:  lim.cut = data;
         REG_CHARGE_RESTART: lim.rst = data;
         default: ;
      endcase
   endtask

   task automatic apply_limits(input limits_type l);
      // upper bits of the temperature words are junk and must be ignored
      csr_put(REG_OVER_VOLTAGE, l.ov);
      csr_put(REG_UNDER_VOLTAGE, l.uv);
      csr_put(REG_OVER_TEMP, {4'($urandom_range(0, 15)), l.ot});
      csr_put(REG_UNDER_TEMP, {4'($urandom_range(0, 15)), l.ut});
      csr_put(REG_PRECHARGE_MS, l.pm);
      csr_put(REG_CHARGE_CUTOFF, l.cut);
      csr_put(REG_CHARGE_RESTART, l.rst);
      csr_put(REG_SPARE, 16'($urandom_range(0, 65535)));
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   function automatic limits_type limits_for(input int phase);
      limits_type l;
      case (phase)
         1: l = '{16'hFFFF, 16'h0000, 2000, -1000, 16'd0, 16'd0, 16'hFFFF};
         2: l = '{16'h0000, 16'hFFFF, -1000, 2000, 16'hFFFF, 16'hFFFF, 16'd0};
         // over-voltage below cutoff: the over-voltage clamp on the charge pin shows
         3: l = '{16'd4100, 16'd3000, 600, 0, 16'd100, 16'd4300, 16'd4200};
         default: begin
            l.ov = 16'(4150 + $urandom_range(0, 100));
            l.uv = 16'(2900 + $urandom_range(0, 200));
            l.ot = 12'(450 + $urandom_range(0, 200));
            l.ut = 12'(int'($urandom_range(0, 250)) - 200);
            l.pm = 16'(20 + $urandom_range(0, 580));
            l.cut = 16'(4100 + $urandom_range(0, 80));
            l.rst = 16'(3950 + $urandom_range(0, 140));
         end
      endcase
      return l;
   endfunction

   function automatic logic [MV_W-1:0] mv_near(input int anchor, input int spread);
      int v;
      v = anchor - spread + int'($urandom_range(0, 2 * spread));
      if (v < 0) v = 0;
      else if (v > 65535) v = 65535;
      return v[MV_W-1:0];
   endfunction

   // Mostly plausible pack samples with persistent switches and a moving clock.
   function automatic sample_type next_sample();
      sample_type s;
      int      r;
      int      lo;
      int      hi;
      int      t;
      if ($urandom_range(0, 99) < 7) drv_charger = !drv_charger;
      if ($urandom_range(0, 99) < 7) drv_load = !drv_load;
      r = int'($urandom_range(0, 99));
      if (r < 75) drv_now = drv_now + $urandom_range(1, 60);
      else if (r < 93) drv_now = drv_now + $urandom_range(0, 2 * int'(lim.pm) + 1);
      else drv_now = $urandom();
      r = int'($urandom_range(0, 99));
      if (r < 70) s.min_mv = mv_near(int'(lim.uv) + 300, 250);
      else if (r < 90) s.min_mv = mv_near(int'(lim.uv), 3);
      else s.min_mv = 16'($urandom_range(0, 65535));
      r = int'($urandom_range(0, 99));
      if (r < 55) s.max_mv = mv_near(int'(lim.rst), 120);
      else if (r < 70) s.max_mv = mv_near(int'(lim.cut), 3);
      else if (r < 85) s.max_mv = mv_near(int'(lim.ov), 3);
      else s.max_mv = 16'($urandom_range(0, 65535));
      lo = int'(lim.ut) + 1;
      hi = int'(lim.ot) - 1;
      r = int'($urandom_range(0, 99));
      if (r < 85 && lo <= hi) t = lo + int'($urandom_range(0, hi - lo));
      else if (r < 90) t = int'(lim.ot) + int'($urandom_range(0, 2)) - 1;
      else if (r < 95) t = int'(lim.ut) + int'($urandom_range(0, 2)) - 1;
      else t = -1000 + int'($urandom_range(0, 3000));
      if (t < -1000) t = -1000;
      else if (t > 2000) t = 2000;
      s.temp = t[TEMP_W-1:0];
      s.charger = drv_charger;
      s.load = drv_load;
      s.now = drv_now;
      return s;
   endfunction

   initial begin
      sample_type smp;
      status_type pin;
      status_type no_pin;
      no_pin = '{MODE_IDLE, 1'b0, 1'b0, 1'b0};
      err_count = 0;
      n_sent = 0;
      n_results = 0;
      n_settings = 0;
      mode_seen = '{0, 0, 0, 0, 0};
      send_gap_pct = 13;
      recv_stall_pct = 62;
      lim = '{RST_OVER_VOLTAGE, RST_UNDER_VOLTAGE, RST_OVER_TEMP, RST_UNDER_TEMP,
              RST_PRECHARGE_MS, RST_CHARGE_CUTOFF, RST_CHARGE_RESTART};
      sv_mode = MODE_IDLE;
      sv_pc_start = '0;
      sv_pre = 1'b0;
      sv_load = 1'b0;
      sv_chg = 1'b0;
      drv_charger = 1'b0;
      drv_load = 1'b1;
      drv_now = $urandom();

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_min_cell_mv <= '0;
      req_max_cell_mv <= '0;
      req_temperature <= '0;
      req_charger_present <= 1'b0;
      req_load_request <= 1'b0;
      req_now_ms <= '0;
      req_pinned <= 1'b0;
      req_pin_val <= no_pin;
      csr_wr_en <= 1'b0;
      csr_index <= REG_OVER_VOLTAGE;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i]) begin
         smp = '{opening_plan[i].min_mv, opening_plan[i].max_mv, opening_plan[i].temp,
                 opening_plan[i].charger, opening_plan[i].load, opening_plan[i].now};
         pin = '{opening_plan[i].mode, opening_plan[i].pre, opening_plan[i].load_en,
                 opening_plan[i].chg};
         push_sample(smp, opening_plan[i].pinned, pin);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         send_gap_pct = (phase < 2) ? 13 : (phase < 4) ? 62 : 0;
         recv_stall_pct = (phase < 2) ? 62 : (phase < 4) ? 13 : 0;
         apply_limits(limits_for(phase));
         repeat (ITEMS_PER_PHASE) begin
            smp = next_sample();
            push_sample(smp, 1'b0, no_pin);
         end
      end
      drain_results();

      $display("Ran %0d samples: opening table plus %0d threshold settings, three idle profiles",
               n_sent, n_settings);
      $display("Results by mode idle/precharge/discharge/charge/fault: %0d/%0d/%0d/%0d/%0d",
               mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4]);
      if (err_count == 0) begin
         $display("battery_contactor_mode_control_top_test: PASS");
      end else begin
         $display("battery_contactor_mode_control_top_test: FAIL");
      end
      $finish;
   end

endmodule
